FILE: hdl/bci_pkg.sv
// ----------------------------------------------------------------------------
// bci_pkg
// shared types and codes of the breakpoint curve interpolator
// ----------------------------------------------------------------------------
package bci_pkg;

    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    localparam logic [1:0] OUT_MATCH  = 2'd0;
    localparam logic [1:0] OUT_INTERP = 2'd1;
    localparam logic [1:0] OUT_NODATA = 2'd2;

    typedef struct packed {
        logic               cmd;
        logic [3:0]         slot;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] sample;
    } in_word_t;

    typedef struct packed {
        logic signed [31:0] curve_value;
        logic [1:0]         outcome;
    } out_word_t;

endpackage

FILE: hdl/breakpoint_curve_interpolator.sv
// ----------------------------------------------------------------------------
// breakpoint_curve_interpolator
// piecewise linear interpolation over a table of Q16.16 breakpoints
// ----------------------------------------------------------------------------
// usage: words on s_data carry either a breakpoint write (cmd 0) or a sample
// (cmd 1). writes go into the table as they leave the input register, so
// every sample sees exactly the writes that came before it. each sample
// yields one word on m_data, writes yield none. cfg_data sets the nodata
// value and is always ready; write it only while the block is idle.
// pipeline: a sample accepted on s_data passes through the input register,
// breakpoint search, differences, partial products, the stages of a
// one-bit-per-stage restoring divider and the output register.
// throughput: one word per cycle when not stalled; the divider sets the depth.
// reset: aresetn low clears all valid bits, the table valid bits and sets
// nodata to zero. when the receiver stalls the whole pipeline holds and
// s_ready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module breakpoint_curve_interpolator #(
    parameter int POINTS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  bci_pkg::in_word_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output bci_pkg::out_word_t m_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [31:0]        cfg_data
);

    localparam int IW    = (POINTS > 1) ? $clog2(POINTS) : 1;
    localparam int NP    = 1 << IW;
    localparam int DSTEP = 33;

    typedef struct packed {
        logic [1:0]         outcome;
        logic signed [31:0] value;
        logic signed [31:0] s;
        logic signed [31:0] x0;
        logic signed [31:0] x1;
        logic signed [31:0] y0;
        logic signed [31:0] y1;
    } srch_t;

    typedef struct packed {
        logic [1:0]         outcome;
        logic signed [31:0] value;
        logic               neg;
        logic [32:0]        mag;
        logic [32:0]        dx;
        logic [32:0]        den;
    } diff_t;

    typedef struct packed {
        logic [1:0]         outcome;
        logic signed [31:0] value;
        logic               neg;
        logic [33:0]        p_hh;
        logic [32:0]        p_hl;
        logic [32:0]        p_lh;
        logic [31:0]        p_ll;
        logic [32:0]        den;
    } part_t;

    typedef struct packed {
        logic [1:0]         outcome;
        logic signed [31:0] value;
        logic               neg;
        logic [32:0]        rem;
        logic [32:0]        low;
        logic [32:0]        quo;
        logic [32:0]        den;
    } div_t;

    logic advance;

    logic               in_valid_reg;
    bci_pkg::in_word_t  in_reg;
    logic               srch_valid_reg;
    srch_t              srch_reg;
    srch_t              srch_next;
    logic               diff_valid_reg;
    diff_t              diff_reg;
    logic               part_valid_reg;
    part_t              part_reg;
    logic               div_valid_reg [0:DSTEP];
    div_t               div_reg [0:DSTEP];
    logic               out_valid_reg;
    bci_pkg::out_word_t out_reg;
    logic signed [31:0] nodata_reg;

    logic               tab_valid_reg [POINTS];
    logic signed [31:0] tab_x_reg [POINTS];
    logic signed [31:0] tab_y_reg [POINTS];

    logic [7:0]         slot_ext;
    logic               slot_ok;

    assign advance   = !out_valid_reg || m_ready;
    assign s_ready   = advance;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_reg;
    assign cfg_ready = 1'b1;
    assign slot_ext  = {4'b0000, in_reg.slot};
    assign slot_ok   = slot_ext < 8'(POINTS);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nodata_reg <= '0;
        end else if (cfg_valid) begin
            nodata_reg <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (advance) begin
            in_valid_reg <= s_valid;
        end
        if (advance) begin
            in_reg <= s_data;
        end
    end

    // table update as the write word leaves the input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < POINTS; i++) begin
                tab_valid_reg[i] <= 1'b0;
            end
        end else if (advance && in_valid_reg && in_reg.cmd == bci_pkg::CMD_WRITE
                     && slot_ok) begin
            tab_valid_reg[slot_ext[IW-1:0]] <= 1'b1;
        end
        if (advance && in_valid_reg && in_reg.cmd == bci_pkg::CMD_WRITE && slot_ok) begin
            tab_x_reg[slot_ext[IW-1:0]] <= in_reg.point_x;
            tab_y_reg[slot_ext[IW-1:0]] <= in_reg.point_y;
        end
    end

    // search: exact match by priority, nearest below and above by tournament
    logic               lo_v [2*NP];
    logic signed [31:0] lo_x [2*NP];
    logic signed [31:0] lo_y [2*NP];
    logic               hi_v [2*NP];
    logic signed [31:0] hi_x [2*NP];
    logic signed [31:0] hi_y [2*NP];
    logic               eq_found;
    logic signed [31:0] eq_y;

    always_comb begin
        eq_found = 1'b0;
        eq_y     = '0;
        for (int i = POINTS - 1; i >= 0; i--) begin
            if (tab_valid_reg[i] && tab_x_reg[i] == in_reg.sample) begin
                eq_found = 1'b1;
                eq_y     = tab_y_reg[i];
            end
        end
        for (int n = 0; n < 2 * NP; n++) begin
            lo_v[n] = 1'b0;
            lo_x[n] = '0;
            lo_y[n] = '0;
            hi_v[n] = 1'b0;
            hi_x[n] = '0;
            hi_y[n] = '0;
        end
        for (int i = 0; i < POINTS; i++) begin
            lo_v[NP+i] = tab_valid_reg[i] && (tab_x_reg[i] < in_reg.sample);
            hi_v[NP+i] = tab_valid_reg[i] && !(tab_x_reg[i] < in_reg.sample);
            lo_x[NP+i] = tab_x_reg[i];
            lo_y[NP+i] = tab_y_reg[i];
            hi_x[NP+i] = tab_x_reg[i];
            hi_y[NP+i] = tab_y_reg[i];
        end
        for (int n = NP - 1; n >= 1; n--) begin
            if (lo_v[2*n+1] && (!lo_v[2*n] || lo_x[2*n+1] > lo_x[2*n])) begin
                lo_v[n] = 1'b1;
                lo_x[n] = lo_x[2*n+1];
                lo_y[n] = lo_y[2*n+1];
            end else begin
                lo_v[n] = lo_v[2*n];
                lo_x[n] = lo_x[2*n];
                lo_y[n] = lo_y[2*n];
            end
            if (hi_v[2*n+1] && (!hi_v[2*n] || hi_x[2*n+1] < hi_x[2*n])) begin
                hi_v[n] = 1'b1;
                hi_x[n] = hi_x[2*n+1];
                hi_y[n] = hi_y[2*n+1];
            end else begin
                hi_v[n] = hi_v[2*n];
                hi_x[n] = hi_x[2*n];
                hi_y[n] = hi_y[2*n];
            end
        end
        srch_next.s  = in_reg.sample;
        srch_next.x0 = lo_x[1];
        srch_next.y0 = lo_y[1];
        srch_next.x1 = hi_x[1];
        srch_next.y1 = hi_y[1];
        if (eq_found) begin
            srch_next.outcome = bci_pkg::OUT_MATCH;
            srch_next.value   = eq_y;
        end else if (lo_v[1] && hi_v[1]) begin
            srch_next.outcome = bci_pkg::OUT_INTERP;
            srch_next.value   = lo_y[1];
        end else begin
            srch_next.outcome = bci_pkg::OUT_NODATA;
            srch_next.value   = nodata_reg;
        end
    end

    logic signed [32:0] dy;
    assign dy = 33'(srch_reg.y1) - 33'(srch_reg.y0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            srch_valid_reg <= 1'b0;
            diff_valid_reg <= 1'b0;
            part_valid_reg <= 1'b0;
        end else if (advance) begin
            srch_valid_reg <= in_valid_reg && in_reg.cmd == bci_pkg::CMD_SAMPLE;
            diff_valid_reg <= srch_valid_reg;
            part_valid_reg <= diff_valid_reg;
        end
        if (advance) begin
            srch_reg <= srch_next;

            diff_reg.outcome <= srch_reg.outcome;
            diff_reg.value   <= srch_reg.value;
            diff_reg.neg     <= dy[32];
            diff_reg.mag     <= dy[32] ? 33'(-dy) : 33'(dy);
            diff_reg.dx      <= 33'(33'(srch_reg.s) - 33'(srch_reg.x0));
            diff_reg.den     <= 33'(33'(srch_reg.x1) - 33'(srch_reg.x0));

            part_reg.outcome <= diff_reg.outcome;
            part_reg.value   <= diff_reg.value;
            part_reg.neg     <= diff_reg.neg;
            part_reg.p_hh    <= diff_reg.mag[32:16] * diff_reg.dx[32:16];
            part_reg.p_hl    <= diff_reg.mag[32:16] * diff_reg.dx[15:0];
            part_reg.p_lh    <= diff_reg.mag[15:0] * diff_reg.dx[32:16];
            part_reg.p_ll    <= diff_reg.mag[15:0] * diff_reg.dx[15:0];
            part_reg.den     <= diff_reg.den;
        end
    end

    logic [65:0] prod;
    assign prod = (66'(part_reg.p_hh) << 32)
                + ((66'(part_reg.p_hl) + 66'(part_reg.p_lh)) << 16)
                + 66'(part_reg.p_ll);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_valid_reg[0] <= 1'b0;
        end else if (advance) begin
            div_valid_reg[0] <= part_valid_reg;
        end
        if (advance) begin
            div_reg[0].outcome <= part_reg.outcome;
            div_reg[0].value   <= part_reg.value;
            div_reg[0].neg     <= part_reg.neg;
            div_reg[0].rem     <= prod[65:33];
            div_reg[0].low     <= prod[32:0];
            div_reg[0].quo     <= '0;
            div_reg[0].den     <= part_reg.den;
        end
    end

    // one quotient bit per stage
    for (genvar k = 0; k < DSTEP; k++) begin : g_div
        logic [33:0] trial;
        logic        take;
        assign trial = {div_reg[k].rem, div_reg[k].low[32]};
        assign take  = trial >= {1'b0, div_reg[k].den};

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                div_valid_reg[k+1] <= 1'b0;
            end else if (advance) begin
                div_valid_reg[k+1] <= div_valid_reg[k];
            end
            if (advance) begin
                div_reg[k+1].outcome <= div_reg[k].outcome;
                div_reg[k+1].value   <= div_reg[k].value;
                div_reg[k+1].neg     <= div_reg[k].neg;
                div_reg[k+1].rem     <= take ? 33'(trial - {1'b0, div_reg[k].den})
                                             : trial[32:0];
                div_reg[k+1].low     <= {div_reg[k].low[31:0], 1'b0};
                div_reg[k+1].quo     <= {div_reg[k].quo[31:0], take};
                div_reg[k+1].den     <= div_reg[k].den;
            end
        end
    end

    logic [33:0] interp;
    assign interp = div_reg[DSTEP].neg
                  ? 34'(div_reg[DSTEP].value) - 34'(div_reg[DSTEP].quo)
                  : 34'(div_reg[DSTEP].value) + 34'(div_reg[DSTEP].quo);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= div_valid_reg[DSTEP];
        end
        if (advance) begin
            out_reg.outcome     <= div_reg[DSTEP].outcome;
            out_reg.curve_value <= (div_reg[DSTEP].outcome == bci_pkg::OUT_INTERP)
                                 ? interp[31:0] : div_reg[DSTEP].value;
        end
    end

endmodule

FILE: hdl/bci_checker.sv
// ----------------------------------------------------------------------------
// bci_checker
// port level checks of the breakpoint curve interpolator
// ----------------------------------------------------------------------------
module bci_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input bci_pkg::out_word_t m_data
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word changed while stalled");

    a_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.outcome == bci_pkg::OUT_MATCH
                     || m_data.outcome == bci_pkg::OUT_INTERP
                     || m_data.outcome == bci_pkg::OUT_NODATA))
        else $error("undefined outcome code");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("input taken while pipeline stalled");

endmodule

bind breakpoint_curve_interpolator bci_checker u_bci_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
